/* src/tbf_pkg.sv */
// tbf_pkg: shared types, constants, grids and factor table for the tube bank factor lookup
// used by every module of the block; depends on nothing

package tbf_pkg;

	// fixed-point setup
	localparam int RATIO_FRAC_BITS = 16;
	localparam int REG_W    = 20;
	localparam int RE_W     = 24;
	localparam int FA_W     = 16;
	localparam int TQ_W     = 15;
	localparam int WT_W     = 17;
	localparam int WT_FRAC  = 16;
	localparam int GW       = RATIO_FRAC_BITS + 4;
	localparam int NUM_W    = RATIO_FRAC_BITS + 21;
	localparam int DEN_W    = (GW > REG_W) ? GW : REG_W;
	localparam int CNT_W    = $clog2(NUM_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << WT_FRAC);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSVERSE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONGITUDINAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER     = 2'd2;

	localparam logic [REG_W-1:0] RST_TRANSVERSE   = 20'd50800;
	localparam logic [REG_W-1:0] RST_LONGITUDINAL = 20'd50800;
	localparam logic [REG_W-1:0] RST_DIAMETER     = 20'd25400;

	// pitch ratio grids in ratio format
	localparam logic [GW-1:0] ST_GRID [6] = '{
		GW'((64'd3 << RATIO_FRAC_BITS) / 64'd2),
		GW'((64'd4 << RATIO_FRAC_BITS) / 64'd2),
		GW'((64'd6 << RATIO_FRAC_BITS) / 64'd2),
		GW'((64'd8 << RATIO_FRAC_BITS) / 64'd2),
		GW'((64'd10 << RATIO_FRAC_BITS) / 64'd2),
		GW'((64'd12 << RATIO_FRAC_BITS) / 64'd2)
	};
	localparam logic [GW-1:0] SL_GRID [6] = '{
		GW'(((64'd20 << RATIO_FRAC_BITS) + 64'd10) / 64'd20),
		GW'(((64'd22 << RATIO_FRAC_BITS) + 64'd10) / 64'd20),
		GW'(((64'd25 << RATIO_FRAC_BITS) + 64'd10) / 64'd20),
		GW'(((64'd30 << RATIO_FRAC_BITS) + 64'd10) / 64'd20),
		GW'(((64'd40 << RATIO_FRAC_BITS) + 64'd10) / 64'd20),
		GW'(((64'd40 << RATIO_FRAC_BITS) + 64'd10) / 64'd20)
	};

	// reynolds grid, spans are 32 times the reduced divisors
	localparam logic [15:0] RE_LO  = 16'd8000;
	localparam logic [15:0] RE_MID = 16'd20000;
	localparam logic [15:0] RE_HI  = 16'd40000;
	localparam int RE_OFF_W = 15;
	localparam int RE_N_W   = RE_OFF_W + 11;
	localparam int RE_D_W   = 10;
	localparam int RE_K     = 40;
	localparam int RE_M_W   = 32;
	localparam int RE_P_W   = RE_N_W + RE_M_W;
	localparam logic [RE_D_W-1:0] RE_D1 = 10'd375;
	localparam logic [RE_D_W-1:0] RE_D2 = 10'd625;
	localparam logic [RE_M_W-1:0] RE_M1 = RE_M_W'((64'd1 << RE_K) / 64'd375);
	localparam logic [RE_M_W-1:0] RE_M2 = RE_M_W'((64'd1 << RE_K) / 64'd625);

	// factor table in q1.14, index i*20 + j*4 + k
	localparam int TBL_N = 120;
	localparam int TBL_IDX_W = 7;
	localparam logic [TBL_IDX_W-1:0] TBL_I_STRIDE = 7'd20;
	localparam logic [TBL_IDX_W-1:0] TBL_J_STRIDE = 7'd4;
	localparam logic [TQ_W-1:0] FA_TBL [TBL_N] = '{
		15'd6390,  15'd9011,  15'd11305, 15'd11796,
		15'd8192,  15'd11633, 15'd14909, 15'd14582,
		15'd13107, 15'd14254, 15'd16220, 15'd16220,
		15'd15729, 15'd14746, 15'd17531, 15'd17203,
		15'd15892, 15'd14746, 15'd18022, 15'd17859,
		15'd5898,  15'd7373,  15'd9667,  15'd11141,
		15'd7700,  15'd9994,  15'd13435, 15'd13763,
		15'd11796, 15'd12943, 15'd15073, 15'd15073,
		15'd15237, 15'd13763, 15'd16384, 15'd16384,
		15'd15565, 15'd14254, 15'd17203, 15'd17039,
		15'd5407,  15'd6390,  15'd8520,  15'd9667,
		15'd6881,  15'd9175,  15'd12124, 15'd12943,
		15'd10977, 15'd11960, 15'd13926, 15'd13763,
		15'd14746, 15'd12943, 15'd14909, 15'd14909,
		15'd15073, 15'd13435, 15'd15892, 15'd15729,
		15'd5407,  15'd6062,  15'd7864,  15'd8684,
		15'd6717,  15'd8847,  15'd11469, 15'd12780,
		15'd10486, 15'd11633, 15'd13271, 15'd13107,
		15'd13763, 15'd12616, 15'd14418, 15'd14418,
		15'd14582, 15'd13107, 15'd15237, 15'd15729,
		15'd5734,  15'd6226,  15'd7537,  15'd8192,
		15'd7045,  15'd9011,  15'd11633, 15'd12943,
		15'd10322, 15'd11469, 15'd13107, 15'd13435,
		15'd12943, 15'd12288, 15'd14418, 15'd14582,
		15'd13926, 15'd12943, 15'd15237, 15'd15729,
		15'd6554,  15'd6390,  15'd7373,  15'd7864,
		15'd7700,  15'd9339,  15'd11960, 15'd13435,
		15'd10158, 15'd11141, 15'd13435, 15'd14582,
		15'd11633, 15'd12124, 15'd14582, 15'd14909,
		15'd13107, 15'd12780, 15'd15237, 15'd15729
	};
	localparam logic [FA_W-1:0] FA_MIN = 16'd5407;
	localparam logic [FA_W-1:0] FA_MAX = 16'd18022;

	// geometry sequencer
	typedef enum logic [1:0] {
		GS_IDLE,
		GS_LAUNCH,
		GS_WAIT
	} geom_state_t;

	typedef enum logic [1:0] {
		STEP_ST_RATIO,
		STEP_ST_WT,
		STEP_SL_RATIO,
		STEP_SL_WT
	} geom_step_t;

	// per-configuration interpolation setup
	typedef struct packed {
		logic [2:0]      ist;
		logic [1:0]      jsl;
		logic [WT_W-1:0] tst;
		logic [WT_W-1:0] tsl;
	} geom_t;

	// a + round((b - a) * t / 2^16), same as the weighted sum with half-up rounding
	function automatic logic [TQ_W-1:0] lerp_q(input logic [TQ_W-1:0] a,
			input logic [TQ_W-1:0] b, input logic [WT_W-1:0] t);
		logic signed [TQ_W+1:0]        d;
		logic signed [WT_W:0]          ts;
		logic signed [TQ_W+WT_W+2:0]   p;
		logic signed [TQ_W+WT_W+2:0]   sh;
		logic [TQ_W+1:0]               r;
		d  = $signed({2'b00, b}) - $signed({2'b00, a});
		ts = $signed({1'b0, t});
		p  = d * ts + 35'sd32768;
		sh = p >>> WT_FRAC;
		r  = {2'b00, a} + sh[TQ_W+1:0];
		return r[TQ_W-1:0];
	endfunction

endpackage

/* src/tbf_if.sv */
// tbf_in_if and tbf_out_if: valid/ready channels for reynolds requests and factor results
// depends on tbf_pkg

interface tbf_in_if;
	logic                      valid;
	logic                      ready;
	logic [tbf_pkg::RE_W-1:0]  reynolds_number;
	modport source(output valid, output reynolds_number, input ready);
	modport sink(input valid, input reynolds_number, output ready);
endinterface

interface tbf_out_if;
	logic                      valid;
	logic                      ready;
	logic [tbf_pkg::FA_W-1:0]  arrangement_factor;
	modport source(output valid, output arrangement_factor, input ready);
	modport sink(input valid, input arrangement_factor, output ready);
endinterface

/* src/tbf_div.sv */
// tbf_div: restoring divider, one quotient bit per cycle
// depends on tbf_pkg

module tbf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tbf_pkg::NUM_W-1:0]  num,
	input  logic [tbf_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [tbf_pkg::NUM_W-1:0]  quo
);
	logic                        busy_q;
	logic                        done_q;
	logic [tbf_pkg::CNT_W-1:0]   cnt_q;
	logic [tbf_pkg::NUM_W-1:0]   acc_q;
	logic [tbf_pkg::DEN_W-1:0]   rem_q;
	logic [tbf_pkg::DEN_W-1:0]   den_q;
	logic [tbf_pkg::DEN_W:0]     trial;
	logic [tbf_pkg::DEN_W:0]     diff;
	logic                        ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, acc_q[tbf_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tbf_pkg::CNT_W'(tbf_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tbf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[tbf_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? diff[tbf_pkg::DEN_W-1:0] : trial[tbf_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = acc_q;

endmodule

/* src/tbf_geom.sv */
// tbf_geom: configuration registers and the pitch-ratio setup (ratios, intervals, weights)
// depends on tbf_pkg and tbf_div

module tbf_geom (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbf_pkg::REG_W-1:0]       cfg_wdata,
	output tbf_pkg::geom_t                  geom,
	output logic                            ready
);
	logic [tbf_pkg::REG_W-1:0]  st_q;
	logic [tbf_pkg::REG_W-1:0]  sl_q;
	logic [tbf_pkg::REG_W-1:0]  dia_q;
	logic                       pending_q;
	tbf_pkg::geom_state_t       state_q;
	tbf_pkg::geom_state_t       state_d;
	tbf_pkg::geom_step_t        step_q;
	logic                       last_step;
	logic                       div_start;
	logic                       div_done;
	logic [tbf_pkg::NUM_W-1:0]  div_num;
	logic [tbf_pkg::DEN_W-1:0]  div_den;
	logic [tbf_pkg::NUM_W-1:0]  div_quo;
	logic [tbf_pkg::GW-1:0]     off_q;
	logic [tbf_pkg::GW-1:0]     span_q;
	logic [2:0]                 ist_q;
	logic [1:0]                 jsl_q;
	logic [tbf_pkg::WT_W-1:0]   tst_q;
	logic [tbf_pkg::WT_W-1:0]   tsl_q;
	logic [tbf_pkg::GW-1:0]     g [6];
	logic [2:0]                 top;
	logic [tbf_pkg::GW-1:0]     xc;
	logic [2:0]                 idx;
	logic                       found;
	logic [tbf_pkg::GW-1:0]     off;
	logic [tbf_pkg::GW-1:0]     span;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= tbf_pkg::RST_TRANSVERSE;
			sl_q  <= tbf_pkg::RST_LONGITUDINAL;
			dia_q <= tbf_pkg::RST_DIAMETER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbf_pkg::CFG_TRANSVERSE:   st_q  <= cfg_wdata;
				tbf_pkg::CFG_LONGITUDINAL: sl_q  <= cfg_wdata;
				tbf_pkg::CFG_DIAMETER:     dia_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign last_step = step_q == tbf_pkg::STEP_SL_WT;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbf_pkg::GS_IDLE:   if (pending_q) state_d = tbf_pkg::GS_LAUNCH;
			tbf_pkg::GS_LAUNCH: state_d = tbf_pkg::GS_WAIT;
			tbf_pkg::GS_WAIT: begin
				if (div_done) state_d = last_step ? tbf_pkg::GS_IDLE : tbf_pkg::GS_LAUNCH;
			end
			default: state_d = tbf_pkg::GS_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start = state_q == tbf_pkg::GS_LAUNCH;
		ready     = (state_q == tbf_pkg::GS_IDLE) && !pending_q;
	end

	// state, step and recompute request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tbf_pkg::GS_IDLE;
			step_q    <= tbf_pkg::STEP_ST_RATIO;
			pending_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pending_q <= 1'b1;
			end else if (state_q == tbf_pkg::GS_IDLE) begin
				pending_q <= 1'b0;
			end
			if (state_q == tbf_pkg::GS_IDLE && pending_q) begin
				step_q <= tbf_pkg::STEP_ST_RATIO;
			end else if (state_q == tbf_pkg::GS_WAIT && div_done && !last_step) begin
				step_q <= tbf_pkg::geom_step_t'(step_q + 2'd1);
			end
		end
	end

	// divider operands
	always_comb begin
		unique case (step_q)
			tbf_pkg::STEP_ST_RATIO: begin
				div_num = tbf_pkg::NUM_W'({st_q, {tbf_pkg::RATIO_FRAC_BITS{1'b0}}});
				div_den = tbf_pkg::DEN_W'(dia_q);
			end
			tbf_pkg::STEP_SL_RATIO: begin
				div_num = tbf_pkg::NUM_W'({sl_q, {tbf_pkg::RATIO_FRAC_BITS{1'b0}}});
				div_den = tbf_pkg::DEN_W'(dia_q);
			end
			default: begin
				div_num = tbf_pkg::NUM_W'({off_q, {tbf_pkg::WT_FRAC{1'b0}}});
				div_den = tbf_pkg::DEN_W'(span_q);
			end
		endcase
	end

	tbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// clamp the ratio and find the first interval holding it
	always_comb begin
		g   = (step_q == tbf_pkg::STEP_SL_RATIO) ? tbf_pkg::SL_GRID : tbf_pkg::ST_GRID;
		top = (step_q == tbf_pkg::STEP_SL_RATIO) ? 3'd4 : 3'd5;
		if (div_quo > tbf_pkg::NUM_W'(g[top])) begin
			xc = g[top];
		end else if (div_quo < tbf_pkg::NUM_W'(g[1])) begin
			xc = g[1];
		end else begin
			xc = div_quo[tbf_pkg::GW-1:0];
		end
		idx   = top - 3'd1;
		found = 1'b0;
		for (int n = 0; n < 5; n++) begin
			if (!found && 3'(n) < top && xc <= g[n+1]) begin
				idx   = 3'(n);
				found = 1'b1;
			end
		end
		off  = xc - g[idx];
		span = g[idx + 3'd1] - g[idx];
	end

	// capture setup results
	always_ff @(posedge clk) begin
		if (state_q == tbf_pkg::GS_WAIT && div_done) begin
			case (step_q)
				tbf_pkg::STEP_ST_RATIO: begin
					off_q  <= off;
					span_q <= span;
					ist_q  <= idx;
				end
				tbf_pkg::STEP_SL_RATIO: begin
					off_q  <= off;
					span_q <= span;
					jsl_q  <= idx[1:0];
				end
				tbf_pkg::STEP_ST_WT: tst_q <= div_quo[tbf_pkg::WT_W-1:0];
				default:             tsl_q <= div_quo[tbf_pkg::WT_W-1:0];
			endcase
		end
	end

	assign geom.ist = ist_q;
	assign geom.jsl = jsl_q;
	assign geom.tst = tst_q;
	assign geom.tsl = tsl_q;

endmodule

/* src/tbf_interp.sv */
// tbf_interp: five-stage reynolds locate, table fetch and trilinear interpolation pipeline
// depends on tbf_pkg and the tbf_in_if / tbf_out_if interfaces

module tbf_interp (
	input  logic            clk,
	input  logic            arst_n,
	input  tbf_pkg::geom_t  geom,
	input  logic            geom_ready,
	tbf_in_if.sink          in_ch,
	tbf_out_if.source       out_ch
);
	logic                           en;
	logic                           acc;
	logic [15:0]                    re_c;
	logic [1:0]                     k_c;
	logic [tbf_pkg::RE_OFF_W-1:0]   off_c;
	logic [tbf_pkg::TBL_IDX_W-1:0]  base;

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [1:0]                     k_s1, k_s2;
	logic [tbf_pkg::RE_OFF_W-1:0]   off_s1;
	logic [tbf_pkg::TQ_W-1:0]       c_s2 [8];
	logic [tbf_pkg::RE_N_W-1:0]     n_s2, n_s3;
	logic [tbf_pkg::RE_D_W-1:0]     d_s2, d_s3;
	logic [tbf_pkg::RE_P_W-1:0]     prod_s2;
	logic [tbf_pkg::TQ_W-1:0]       l_s3 [4];
	logic [tbf_pkg::WT_W-1:0]       q_s3;
	logic [tbf_pkg::RE_N_W-1:0]     qd_s3;
	logic                           full_s3;
	logic [tbf_pkg::WT_W-1:0]       q_est;
	logic [tbf_pkg::RE_N_W-1:0]     rem;
	logic [tbf_pkg::TQ_W-1:0]       m_s4 [2];
	logic [tbf_pkg::WT_W-1:0]       t_s4;
	logic [tbf_pkg::TQ_W-1:0]       fa_s5;
	logic                           skid_v_q;
	logic [tbf_pkg::FA_W-1:0]       skid_q;

	// the pipeline moves whenever the skid register is empty
	assign en          = !skid_v_q;
	assign in_ch.ready = en && geom_ready;
	assign acc         = in_ch.valid && in_ch.ready;

	// clamp reynolds and pick its interval
	always_comb begin
		if (in_ch.reynolds_number > tbf_pkg::RE_W'(tbf_pkg::RE_HI)) begin
			re_c = tbf_pkg::RE_HI;
		end else if (in_ch.reynolds_number < tbf_pkg::RE_W'(tbf_pkg::RE_LO)) begin
			re_c = tbf_pkg::RE_LO;
		end else begin
			re_c = in_ch.reynolds_number[15:0];
		end
		if (re_c == tbf_pkg::RE_LO) begin
			k_c   = 2'd0;
			off_c = '0;
		end else if (re_c <= tbf_pkg::RE_MID) begin
			k_c   = 2'd1;
			off_c = tbf_pkg::RE_OFF_W'(re_c - tbf_pkg::RE_LO);
		end else begin
			k_c   = 2'd2;
			off_c = tbf_pkg::RE_OFF_W'(re_c - tbf_pkg::RE_MID);
		end
	end

	// table base for the lower corner
	assign base = tbf_pkg::TBL_IDX_W'(geom.ist) * tbf_pkg::TBL_I_STRIDE
		+ tbf_pkg::TBL_IDX_W'(geom.jsl) * tbf_pkg::TBL_J_STRIDE
		+ tbf_pkg::TBL_IDX_W'(k_s1);

	// weight estimate and remainder of the reynolds division
	assign q_est = prod_s2[tbf_pkg::RE_K +: tbf_pkg::WT_W];
	assign rem   = n_s3 - qd_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: located reynolds
			k_s1   <= k_c;
			off_s1 <= off_c;
			// s2: corner fetch and reciprocal multiply
			for (int n = 0; n < 8; n++) begin
				c_s2[n] <= tbf_pkg::FA_TBL[base
					+ tbf_pkg::TBL_IDX_W'(n % 2) * tbf_pkg::TBL_I_STRIDE
					+ tbf_pkg::TBL_IDX_W'((n / 2) % 2) * tbf_pkg::TBL_J_STRIDE
					+ tbf_pkg::TBL_IDX_W'(n / 4)];
			end
			k_s2    <= k_s1;
			n_s2    <= {off_s1, 11'd0};
			d_s2    <= (k_s1 == 2'd2) ? tbf_pkg::RE_D2 : tbf_pkg::RE_D1;
			prod_s2 <= tbf_pkg::RE_P_W'({off_s1, 11'd0})
				* tbf_pkg::RE_P_W'((k_s1 == 2'd2) ? tbf_pkg::RE_M2 : tbf_pkg::RE_M1);
			// s3: transverse lerps and remainder product
			for (int q = 0; q < 4; q++) begin
				l_s3[q] <= tbf_pkg::lerp_q(c_s2[2*q], c_s2[2*q+1], geom.tst);
			end
			q_s3    <= q_est;
			qd_s3   <= tbf_pkg::RE_N_W'(q_est * d_s2);
			n_s3    <= n_s2;
			d_s3    <= d_s2;
			full_s3 <= k_s2 == 2'd0;
			// s4: longitudinal lerps and corrected reynolds weight
			for (int q = 0; q < 2; q++) begin
				m_s4[q] <= tbf_pkg::lerp_q(l_s3[2*q], l_s3[2*q+1], geom.tsl);
			end
			if (full_s3) begin
				t_s4 <= tbf_pkg::WT_ONE;
			end else if (rem >= tbf_pkg::RE_N_W'(d_s3)) begin
				t_s4 <= q_s3 + 1'b1;
			end else begin
				t_s4 <= q_s3;
			end
			// s5: reynolds lerp
			fa_s5 <= tbf_pkg::lerp_q(m_s4[0], m_s4[1], t_s4);
		end
	end

	// skid register holds a result refused downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= v_s5 && !out_ch.ready;
		end else if (out_ch.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) skid_q <= tbf_pkg::FA_W'(fa_s5);
	end

	assign out_ch.valid              = skid_v_q || v_s5;
	assign out_ch.arrangement_factor = skid_v_q ? skid_q : tbf_pkg::FA_W'(fa_s5);

endmodule

/* src/tube_bank_factor_trilinear_lookup.sv */
// tube_bank_factor_trilinear_lookup: top level of the tube bank arrangement-factor lookup
// depends on tbf_pkg, tbf_if, tbf_geom and tbf_interp
//
//   channel    dir  payload                  width
//   reynolds   in   reynolds_number          24
//   factor     out  arrangement_factor       16
//   cfg        in   cfg_index / cfg_wdata    2 / 20
//
// one request per cycle while reynolds.ready is high; each result passes stages s1 to s5
// after reset and after every register write the geometry unit runs four serial
// divides on one shared divider, each a launch, 37 steps and a handoff, and
// reynolds.ready stays low until the last one is done
// a refused result parks in a skid register; the pipeline freezes only while it is full
// arst_n clears all valid bits and control, registers return to their reset values

module tube_bank_factor_trilinear_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	tbf_in_if.sink                          reynolds,
	tbf_out_if.source                       factor,
	input  logic                            cfg_we,
	input  logic [tbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbf_pkg::REG_W-1:0]       cfg_wdata
);
	tbf_pkg::geom_t  geom;
	logic            geom_ready;

	// per-configuration setup
	tbf_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.geom      (geom),
		.ready     (geom_ready)
	);

	// per-request pipeline
	tbf_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.geom_ready (geom_ready),
		.in_ch      (reynolds),
		.out_ch     (factor)
	);

endmodule

/* src/tbf_checker.sv */
// tbf_checker: port-level assertions for the tube bank factor lookup, bound to the top level
// depends on tbf_pkg and tube_bank_factor_trilinear_lookup

module tbf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [tbf_pkg::FA_W-1:0]   out_data
);

	// a refused result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("factor result changed while stalled");

	// interpolation never leaves the table's range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data >= tbf_pkg::FA_MIN && out_data <= tbf_pkg::FA_MAX)
		else $error("factor outside table range");

	// a register write blocks new requests until the setup is redone
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("request accepted before geometry recompute");

endmodule

bind tube_bank_factor_trilinear_lookup tbf_checker u_tbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.in_ready  (reynolds.ready),
	.out_valid (factor.valid),
	.out_ready (factor.ready),
	.out_data  (factor.arrangement_factor)
);
